// File: sv/lzss_decoder_top_macros.svh
// Assertion macros shared by the LZSS decoder checker.
// Depends on nothing; clock and reset are named clock and reset by the user.
`ifndef LZSS_DECODER_TOP_MACROS_SVH
`define LZSS_DECODER_TOP_MACROS_SVH

// Checked only outside reset.
`define LZD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define LZD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/lzss_pkg.sv
// Shared constants and types of the LZSS decoder.
// No dependencies; used by every RTL module of the block.
package lzss_pkg;

   localparam int BYTE_W        = 8;
   localparam int WIN_BYTES     = 4096;
   localparam int WIN_AW        = $clog2(WIN_BYTES);
   localparam int LIT_LIMIT_DEF = 2;

   localparam logic [BYTE_W-1:0] FILL_BYTE = 8'h20;

   // one access to the window memory
   typedef struct packed {
      logic              we;
      logic [WIN_AW-1:0] waddr;
      logic [BYTE_W-1:0] wdata;
      logic              re;
      logic [WIN_AW-1:0] raddr;
   } mem_req_type;

   // one decoded byte on its way out
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              last;
   } out_item_type;

endpackage

// File: sv/lzss_win_ram.sv
// 4096 x 8 window memory, one write and one read port, registered read.
// Depends on lzss_pkg.
module lzss_win_ram
   import lzss_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       mreq,
   output logic [BYTE_W-1:0] rdata
);

   logic [BYTE_W-1:0] mem [WIN_BYTES];
   logic [BYTE_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mreq.we) begin
         mem[mreq.waddr] <= mreq.wdata;
      end
      if (mreq.re) begin
         rdata_ff <= mem[mreq.raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/lzss_out_fifo.sv
// Two-entry output queue that decouples decoding from the result channel.
// Depends on lzss_pkg.
module lzss_out_fifo
   import lzss_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  out_item_type push_item,
   input  logic         rsp_tready,
   output logic         rsp_tvalid,
   output out_item_type head,
   output logic         pop,
   output logic [1:0]   count
);

   out_item_type head_ff, head_in;
   out_item_type tail_ff, tail_in;
   logic [1:0]   cnt_ff, cnt_in;

   assign pop = (cnt_ff != 2'd0) && rsp_tready;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      unique case ({push, pop})
         2'b10: begin
            if (cnt_ff == 2'd0) begin
               head_in = push_item;
            end else begin
               tail_in = push_item;
            end
            cnt_in = cnt_ff + 2'd1;
         end
         2'b01: begin
            head_in = tail_ff;
            cnt_in  = cnt_ff - 2'd1;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               head_in = push_item;
            end else begin
               head_in = tail_ff;
               tail_in = push_item;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign head       = head_ff;
   assign count      = cnt_ff;

endmodule

// File: sv/lzss_ctrl.sv
// Stream parser and copy sequencer of the LZSS decoder.
// Depends on lzss_pkg; drives lzss_win_ram and lzss_out_fifo.
module lzss_ctrl
   import lzss_pkg::*;
#(
   parameter int LITERAL_LIMIT = LIT_LIMIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,
   input  logic [1:0]        fifo_count,
   input  logic              fifo_pop,
   output mem_req_type       mreq,
   input  logic [BYTE_W-1:0] mem_rdata,
   output logic              push,
   output out_item_type      push_item
);

   localparam int COPY_MAX = 15 + LITERAL_LIMIT + 1;
   localparam int LEN_W    = $clog2(COPY_MAX + 1);
   localparam int IDX_W    = $clog2(COPY_MAX);
   localparam logic [2:0] FLAG_LAST = 3'(BYTE_W - 1);

   typedef enum logic [2:0] {ST_FLAG, ST_ITEM, ST_CODE2, ST_READ, ST_WRITE} state_type;

   state_type         state_ff, state_in;
   logic [WIN_AW-1:0] wp_ff, wp_in;
   logic              wrapped_ff, wrapped_in;
   logic [BYTE_W-1:0] flags_ff, flags_in;
   logic [2:0]        fidx_ff, fidx_in;
   logic [BYTE_W-1:0] offh_ff, offh_in;
   logic [WIN_AW-1:0] src_ff, src_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic [LEN_W-1:0]  wr_idx_ff, wr_idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [LEN_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_hit_ff, rd_hit_in;
   logic [BYTE_W-1:0] copy_buf [COPY_MAX];

   logic              take;
   logic              flag_bit;
   logic              lit_take;
   logic [2:0]        occupancy;
   logic              issue;
   logic              wp_carry;
   logic              wp_step;
   logic [BYTE_W-1:0] rd_byte;

   always_comb begin
      unique case (state_ff)
         ST_FLAG, ST_CODE2: req_tready = 1'b1;
         ST_ITEM:           req_tready = (fifo_count != 2'd2);
         default:           req_tready = 1'b0;
      endcase
   end

   assign take     = req_tvalid && req_tready;
   assign flag_bit = flags_ff[fidx_ff];
   assign lit_take = take && (state_ff == ST_ITEM) && flag_bit;

   // queue slots spoken for: stored + in flight - leaving now
   assign occupancy = 3'(fifo_count) + 3'(rd_vld_ff) - 3'(fifo_pop);
   assign issue     = (state_ff == ST_READ) && (rd_cnt_ff != len_ff) && (occupancy < 3'd2);

   // an entry never written since reset reads as the fill byte
   assign rd_byte = rd_hit_ff ? mem_rdata : FILL_BYTE;

   assign wp_step = lit_take || (state_ff == ST_WRITE);
   assign {wp_carry, wp_in} = wp_step ? ({1'b0, wp_ff} + (WIN_AW + 1)'(1)) : {1'b0, wp_ff};

   always_comb begin
      mreq.re    = issue;
      mreq.raddr = src_ff + WIN_AW'(rd_cnt_ff);
      mreq.we    = wp_step;
      mreq.waddr = wp_ff;
      mreq.wdata = lit_take ? req_tdata : copy_buf[wr_idx_ff[IDX_W-1:0]];
   end

   assign push           = lit_take || rd_vld_ff;
   assign push_item.data = rd_vld_ff ? rd_byte : req_tdata;
   assign push_item.last = rd_vld_ff ? (rd_idx_ff == len_ff - LEN_W'(1)) : 1'b1;

   always_comb begin
      state_in   = state_ff;
      wrapped_in = wrapped_ff | wp_carry;
      flags_in   = flags_ff;
      fidx_in    = fidx_ff;
      offh_in    = offh_ff;
      src_in     = src_ff;
      len_in     = len_ff;
      rd_cnt_in  = rd_cnt_ff;
      wr_idx_in  = wr_idx_ff;
      rd_vld_in  = issue;
      rd_idx_in  = rd_cnt_ff;
      rd_hit_in  = wrapped_ff || (mreq.raddr < wp_ff);

      unique case (state_ff)
         ST_ITEM: begin
            if (take) begin
               if (flag_bit) begin
                  if (fidx_ff == FLAG_LAST) begin
                     fidx_in  = 3'd0;
                     state_in = ST_FLAG;
                  end else begin
                     fidx_in = fidx_ff + 3'd1;
                  end
               end else begin
                  offh_in  = req_tdata;
                  state_in = ST_CODE2;
               end
            end
         end
         ST_CODE2: begin
            if (take) begin
               src_in    = {offh_ff, req_tdata[7:4]};
               len_in    = LEN_W'(req_tdata[3:0]) + LEN_W'(LITERAL_LIMIT + 1);
               rd_cnt_in = '0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            if (issue) begin
               rd_cnt_in = rd_cnt_ff + LEN_W'(1);
            end
            if (rd_cnt_ff == len_ff) begin
               wr_idx_in = '0;
               state_in  = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_idx_in = wr_idx_ff + LEN_W'(1);
            if (wr_idx_ff == len_ff - LEN_W'(1)) begin
               if (fidx_ff == FLAG_LAST) begin
                  fidx_in  = 3'd0;
                  state_in = ST_FLAG;
               end else begin
                  fidx_in  = fidx_ff + 3'd1;
                  state_in = ST_ITEM;
               end
            end
         end
         default: begin
            if (take) begin
               flags_in = req_tdata;
               fidx_in  = 3'd0;
               state_in = ST_ITEM;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FLAG;
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
         flags_ff   <= '0;
         fidx_ff    <= '0;
         offh_ff    <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
         flags_ff   <= flags_in;
         fidx_ff    <= fidx_in;
         offh_ff    <= offh_in;
         rd_vld_ff  <= rd_vld_in;
      end
      src_ff    <= src_in;
      len_ff    <= len_in;
      rd_cnt_ff <= rd_cnt_in;
      wr_idx_ff <= wr_idx_in;
      rd_idx_ff <= rd_idx_in;
      rd_hit_ff <= rd_hit_in;
   end

   // source bytes of the running copy, replayed into the window afterwards
   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         copy_buf[rd_idx_ff[IDX_W-1:0]] <= rd_byte;
      end
   end

endmodule

// File: sv/lzss_decoder_top.sv
// Channel   | Dir | Ports                             | Carries
// req       | in  | req_tvalid req_tready req_tdata   | compressed byte (flag/literal/code)
// rsp       | out | rsp_tvalid rsp_tready rsp_tdata   | decoded byte; rsp_tlast ends the run
//
// Flag byte, first code byte and literal are each handled as they are taken.
// A copy of N bytes (N = low nibble + LITERAL_LIMIT + 1) runs in two passes:
// N reads streamed from the single read port of the window memory, then N write-backs.
// Reads pause while the two-entry output queue is full; input stays stalled until the
// write-back ends. Reset is synchronous; unwritten window entries read as spaces
// through a write-pointer fill mark, so no clearing pass is run.
//
// Top level of the LZSS decoder. Depends on lzss_pkg, lzss_ctrl, lzss_win_ram,
// lzss_out_fifo.
module lzss_decoder_top
   import lzss_pkg::*;
#(
   parameter int LITERAL_LIMIT = LIT_LIMIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] in_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // [7:0] out_byte
   output logic              rsp_tlast    // last_of_run
);

   mem_req_type       mreq;
   logic [BYTE_W-1:0] mem_rdata;
   logic              push;
   out_item_type      push_item;
   out_item_type      head;
   logic              fifo_pop;
   logic [1:0]        fifo_count;

   // parser, copy sequencer and window pointer
   lzss_ctrl #(
      .LITERAL_LIMIT(LITERAL_LIMIT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .fifo_count (fifo_count),
      .fifo_pop   (fifo_pop),
      .mreq       (mreq),
      .mem_rdata  (mem_rdata),
      .push       (push),
      .push_item  (push_item)
   );

   // sliding window, registered read
   lzss_win_ram u_win (
      .clock (clock),
      .mreq  (mreq),
      .rdata (mem_rdata)
   );

   // output queue: results wait here while the next input transfer is taken
   lzss_out_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .head       (head),
      .pop        (fifo_pop),
      .count      (fifo_count)
   );

   assign rsp_tdata = head.data;
   assign rsp_tlast = head.last;

endmodule

// File: sv/lzss_decoder_checker.sv
// Port-level checks of the LZSS decoder, bound to lzss_decoder_top.
// Depends on lzss_decoder_top_macros.svh.
`include "lzss_decoder_top_macros.svh"

module lzss_decoder_props (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);

   // a stalled result keeps its payload
   `LZD_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp payload changed while stalled")

   // reset empties the output queue
   `LZD_ASSERT_ALWAYS(a_rst_empty, reset |=> !rsp_tvalid, "result pending right after reset")

   // the parser is ready for a flag byte after reset
   `LZD_ASSERT_ALWAYS(a_rst_ready, reset |=> req_tready, "req not ready after reset")

   // the first transfer after reset is a flag byte and yields nothing
   `LZD_ASSERT_ALWAYS(a_flag_silent, $past(reset) && !reset && req_tvalid && req_tready |=> !rsp_tvalid, "flag byte produced a result")

endmodule

bind lzss_decoder_top lzss_decoder_props u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: tb/sv/lzss_decoder_checker.sv
// Scoreboard for the LZSS decoder: watches both streams, predicts the decoded bytes.
// Depends on lzss_pkg (widths, fill byte, out_item_type).
module lzss_decoder_checker
   import lzss_pkg::*;
#(
   parameter int LITERAL_LIMIT = LIT_LIMIT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [BYTE_W-1:0] rsp_tdata,
   input  logic              rsp_tlast,
   output int unsigned       fail_count,
   output int unsigned       pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COPY_MAX   = 15 + LITERAL_LIMIT + 1;

   typedef enum logic [1:0] {
      AWAIT_FLAG  = 2'd0,
      AWAIT_ITEM  = 2'd1,
      AWAIT_CODE2 = 2'd2
   } parse_state_type;

   logic [BYTE_W-1:0] window_mem [WIN_BYTES];
   logic [WIN_AW-1:0] wr_ptr;
   logic [BYTE_W-1:0] flag_reg;
   logic [2:0]        flag_idx;
   parse_state_type   parse_state;
   logic [BYTE_W-1:0] offset_hi;
   out_item_type      decoded_q [$];

   initial begin
      fail_count      = 0;
      pending_results = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns  mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   task automatic clear_decoder();
      for (int i = 0; i < WIN_BYTES; i++)
         window_mem[i] = FILL_BYTE;
      wr_ptr      = '0;
      flag_reg    = '0;
      flag_idx    = '0;
      parse_state = AWAIT_FLAG;
      offset_hi   = '0;
      decoded_q.delete();
   endtask

   task automatic append_window(input logic [BYTE_W-1:0] b);
      window_mem[wr_ptr] = b;
      wr_ptr = wr_ptr + 1'b1;
   endtask

   // after 8 items the next byte is a new flag byte
   task automatic next_item();
      if (flag_idx == 3'd7) begin
         flag_idx    = '0;
         parse_state = AWAIT_FLAG;
      end else begin
         flag_idx    = flag_idx + 1'b1;
         parse_state = AWAIT_ITEM;
      end
   endtask

   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      logic [WIN_AW-1:0] src;
      logic [WIN_AW-1:0] rd_addr;
      logic [BYTE_W-1:0] copy_bytes [COPY_MAX];
      int                run_len;
      out_item_type      item;
      unique case (parse_state)
         AWAIT_ITEM: begin
            if (flag_reg[flag_idx]) begin
               append_window(b);
               item.data = b;
               item.last = 1'b1;
               decoded_q.push_back(item);
               next_item();
            end else begin
               offset_hi   = b;
               parse_state = AWAIT_CODE2;
            end
         end
         AWAIT_CODE2: begin
            src     = {offset_hi, b[7:4]};
            run_len = int'(b[3:0]) + LITERAL_LIMIT + 1;
            if (run_len > COPY_MAX)
               run_len = COPY_MAX;
            // whole source read first: an overlapping copy sees the old window
            for (int i = 0; i < run_len; i++) begin
               rd_addr       = src + WIN_AW'(i);
               copy_bytes[i] = window_mem[rd_addr];
               item.data     = copy_bytes[i];
               item.last     = (i == run_len - 1);
               decoded_q.push_back(item);
            end
            for (int i = 0; i < run_len; i++)
               append_window(copy_bytes[i]);
            next_item();
         end
         default: begin
            flag_reg    = b;
            flag_idx    = '0;
            parse_state = AWAIT_ITEM;
         end
      endcase
   endtask

   task automatic check_result();
      out_item_type want;
      if (decoded_q.size() == 0) begin
         report_mismatch($sformatf("unexpected output byte %02h last %0b",
                                   rsp_tdata, rsp_tlast));
      end else begin
         want = decoded_q.pop_front();
         if (rsp_tdata !== want.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", rsp_tdata, want.data));
         if (rsp_tlast !== want.last)
            report_mismatch($sformatf("last_of_run %0b, want %0b (byte %02h)",
                                      rsp_tlast, want.last, want.data));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
      end else begin
         if (req_tvalid && req_tready)
            decode_byte(req_tdata);
         if (rsp_tvalid && rsp_tready)
            check_result();
      end
      pending_results = decoded_q.size();
   end

endmodule

// File: tb/sv/tb_lzss_decoder_top.sv
// Testbench top for the LZSS decoder: clock, reset, compressed-stream stimulus, verdict.
// Depends on lzss_pkg, lzss_decoder_top and lzss_decoder_checker.
module tb_lzss_decoder_top
   import lzss_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LITERAL_LIMIT = LIT_LIMIT_DEF;
   localparam int ITEM_TARGET   = 460;
   localparam int DIRECTED_LEN  = 22;
   localparam int PHASE_COUNT   = 4;
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off, fills the block
   localparam int SETTLE_CYCLES = 60;    // settle time after the final drain, beyond the longest copy plus margin
   localparam int STALL_LIMIT   = 4000;  // cycles without any transfer

   logic              clock;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [BYTE_W-1:0] rsp_tdata;
   logic              rsp_tlast;

   int unsigned       fail_count;
   int unsigned       pending_results;

   // knobs of the sender and the receiver, rates in percent
   int                idle_pct  = 0;
   int                stall_pct = 0;
   bit                hold_pending = 1'b0;

   int                bytes_sent = 0;
   // running write position of the window, only used to aim copy offsets
   logic [WIN_AW-1:0] wr_pos = '0;

   int                phase_idle  [PHASE_COUNT] = '{0, 82, 0, 13};
   int                phase_stall [PHASE_COUNT] = '{0, 0, 82, 13};

   lzss_decoder_top #(
      .LITERAL_LIMIT (LITERAL_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [7:0] in_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [7:0] out_byte
      .rsp_tlast  (rsp_tlast)     // last_of_run
   );

   lzss_decoder_checker #(
      .LITERAL_LIMIT (LITERAL_LIMIT)
   ) scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random stalls at the falling edge; on request one long hold-off,
   // counted here so the sender keeps pushing bytes meanwhile.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: any transfer on either stream restarts the count.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // One compressed-byte transfer. Entered and left at a falling edge; tvalid stays
   // high into the next call when no idle cycle is drawn.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_literal(input logic [BYTE_W-1:0] b);
      send_byte(b);
      wr_pos = wr_pos + 1'b1;
   endtask

   // code pair: offset high byte, then {offset low nibble, length nibble}
   task automatic send_code(input logic [WIN_AW-1:0] offset, input logic [3:0] len_nib);
      send_byte(offset[WIN_AW-1:4]);
      send_byte({offset[3:0], len_nib});
      wr_pos = wr_pos + WIN_AW'(int'(len_nib) + LITERAL_LIMIT + 1);
   endtask

   // drop tvalid and wait until every predicted byte has come out
   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // One flag byte plus its eight items. Well-formed groups mostly copy from just
   // behind the write position (overlap when distance < length); noisy ones take
   // random flags and offsets anywhere in the window.
   task automatic send_group(input bit noisy);
      logic [BYTE_W-1:0] flags;
      logic [WIN_AW-1:0] offset;
      logic [3:0]        len_nib;
      int                pick;
      pick = $urandom_range(99);
      if (noisy || pick >= 20)
         flags = BYTE_W'($urandom_range(255));
      else
         flags = (pick < 10) ? 8'h00 : 8'hFF;
      send_byte(flags);
      for (int i = 0; i < 8; i++) begin
         if (flags[i]) begin
            send_literal(BYTE_W'($urandom_range(255)));
         end else begin
            pick = $urandom_range(99);
            if (noisy || pick < 10)
               offset = WIN_AW'($urandom_range(WIN_BYTES - 1));
            else if (pick < 15)
               offset = pick[0] ? '1 : '0;
            else
               offset = wr_pos - WIN_AW'($urandom_range(40, 1));
            pick = $urandom_range(99);
            if (pick < 10)
               len_nib = 4'h0;
            else if (pick < 20)
               len_nib = 4'hF;
            else
               len_nib = 4'($urandom_range(15));
            send_code(offset, len_nib);
         end
      end
   endtask

   initial begin
      int phase_target;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: eight literals at the byte extremes, then alternating literals and
      // codes - shortest copy from offset 0, longest copy wrapping past the window
      // end (reads unwritten spaces), and overlapping copies one and two behind.
      send_byte(8'hFF);
      send_literal(8'h00);
      send_literal(8'hFF);
      send_literal(8'h55);
      send_literal(8'hAA);
      send_literal(8'h01);
      send_literal(8'h80);
      send_literal(8'h7F);
      send_literal(8'hFE);
      send_byte(8'h55);
      send_literal(8'h3C);
      send_code('0, 4'h0);
      send_literal(8'hC3);
      send_code('1, 4'hF);
      send_literal(8'h81);
      send_code(wr_pos - 1'b1, 4'hF);
      send_literal(8'h42);
      send_code(wr_pos - 2'd2, 4'h5);
      drain_outputs();

      // Random part in idling phases. Phase 0 runs at full rate while the receiver
      // holds off for a long stretch; every phase ends with the sender pausing
      // until all decoded bytes are out.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         idle_pct     = phase_idle[p];
         stall_pct    = phase_stall[p];
         phase_target = DIRECTED_LEN + (p + 1) * (ITEM_TARGET - DIRECTED_LEN) / PHASE_COUNT;
         if (p == 0)
            hold_pending = 1'b1;
         while (bytes_sent < phase_target)
            send_group($urandom_range(99) < 15);
         drain_outputs();
      end

      // Stream ends inside a code item: flag byte with a copy first, then only the
      // offset byte. Nothing may come out of it.
      send_byte(8'hFE);
      send_byte(BYTE_W'($urandom_range(255)));
      drain_outputs();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/lzss_pkg.sv
sv/lzss_win_ram.sv
sv/lzss_out_fifo.sv
sv/lzss_ctrl.sv
sv/lzss_decoder_top.sv
sv/lzss_decoder_checker.sv
tb/sv/lzss_decoder_checker.sv
tb/sv/tb_lzss_decoder_top.sv
